FILE: design/dld_pkg.sv
// Shared types and constants for the decimal long division unit.
// Used by dld_div_unit and decimal_long_division_unit; depends on nothing.
package dld_pkg;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned MAX_FRAC_W  = 6;

    localparam logic [CFG_INDEX_W-1:0] CFG_DIVISOR  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_FRAC = 2'd1;

    localparam logic [3:0] DIGIT_MAX = 4'd9;

    localparam logic [MAX_FRAC_W-1:0] MAX_FRAC_RESET = 6'd63;

    typedef struct packed {
        logic start;
        logic wide;
    } dld_div_ctrl_t;

    typedef struct packed {
        logic       busy;
        logic       done;
        logic [3:0] quotient;
    } dld_div_stat_t;

endpackage

FILE: design/dld_div_unit.sv
// Iterative restoring divider that produces one saturated decimal quotient digit.
// Depends on dld_pkg for its control and status structs.
module dld_div_unit
    import dld_pkg::*;
#(
    parameter int DIVISOR_BITS = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  dld_div_ctrl_t           ctrl,
    input  logic [DIVISOR_BITS+3:0] dividend,
    input  logic [DIVISOR_BITS-1:0] divisor,
    output dld_div_stat_t           stat,
    output logic [DIVISOR_BITS-1:0] remainder
);

    localparam int RW = DIVISOR_BITS + 4;
    localparam int KW = $clog2(RW);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [RW-1:0]     r_reg, r_next;
    logic [DIVISOR_BITS-1:0] p_reg, p_next;
    logic [KW-1:0]     k_reg, k_next;
    logic [3:0]        q_reg, q_next;
    logic              sat_reg, sat_next;

    logic [DIVISOR_BITS:0] p_shift;
    logic [DIVISOR_BITS:0] p_sub;
    logic                  fits;

    assign p_shift = {p_reg, r_reg[k_reg]};
    assign fits    = p_shift >= {1'b0, divisor};
    assign p_sub   = p_shift - {1'b0, divisor};

    always_comb begin
        busy_next = busy_reg;
        done_next = done_reg;
        r_next    = r_reg;
        p_next    = p_reg;
        k_next    = k_reg;
        q_next    = q_reg;
        sat_next  = sat_reg;
        if (ctrl.start) begin
            busy_next = 1'b1;
            done_next = 1'b0;
            r_next    = dividend;
            q_next    = '0;
            sat_next  = 1'b0;
            if (ctrl.wide) begin
                p_next = '0;
                k_next = KW'(RW - 1);
            end else begin
                p_next = dividend[RW-1:4];
                k_next = KW'(3);
            end
        end else if (busy_reg) begin
            p_next   = fits ? p_sub[DIVISOR_BITS-1:0] : p_shift[DIVISOR_BITS-1:0];
            q_next   = {q_reg[2:0], fits};
            sat_next = sat_reg | q_reg[3];
            k_next   = k_reg - KW'(1);
            if (k_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        r_reg   <= r_next;
        p_reg   <= p_next;
        k_reg   <= k_next;
        q_reg   <= q_next;
        sat_reg <= sat_next;
    end

    assign stat.busy     = busy_reg;
    assign stat.done     = done_reg;
    assign stat.quotient = (sat_reg || q_reg > DIGIT_MAX) ? DIGIT_MAX : q_reg;
    assign remainder     = p_reg;

endmodule

FILE: design/decimal_long_division_unit.sv
// Top level of the decimal long division unit: sequencer, registers and output stage.
// Depends on dld_pkg and instantiates dld_div_unit.
//
// Usage: dividend digits enter on the s_ channel, most significant first, with
// s_last_digit on the final integer digit. Each integer digit gives one beat on
// the m_ channel. After the final integer digit, fraction digits follow until the
// remainder is zero or the fraction limit is reached; the final beat has m_last
// set and carries the remainder. A zero divisor gives one error beat per digit.
// The cfg_ channel writes the divisor (index 0) and fraction limit (index 1);
// write only while the block is idle. cfg_ready is always high.
// With the stored remainder below the divisor, an accepted digit takes four restoring
// steps of the shared divider, then moves into the output register, raising m_valid.
// s_ready returns with that beat, so the block takes no new digit before the last one
// is out. If the divisor was lowered in mid-number, that digit runs the divider over
// the full dividend width. Each fraction digit runs the same steps before its beat.
// s_ready is high only between digits.
// Reset restores divisor 1, fraction limit 63 and clears the remainder. When the
// receiver stalls, the result waits in the output register and the sequencer
// holds the next digit in the divider until the register frees.
module decimal_long_division_unit
    import dld_pkg::*;
#(
    parameter int DIVISOR_BITS       = 32,
    parameter int MAX_FRACTION_LIMIT = 63
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [3:0]             s_digit,
    input  logic                   s_last_digit,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [3:0]             m_quotient_digit,
    output logic                   m_is_fraction,
    output logic                   m_last,
    output logic [31:0]            m_final_remainder,
    output logic                   m_divide_error,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data
);

    localparam int RW = DIVISOR_BITS + 4;
    localparam logic [MAX_FRAC_W-1:0] LIMIT_CAP = MAX_FRAC_W'(MAX_FRACTION_LIMIT);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WAIT = 1'b1;

    logic                    state_reg, state_next;
    logic [DIVISOR_BITS-1:0] divisor_reg;
    logic [MAX_FRAC_W-1:0]   max_frac_reg;
    logic [DIVISOR_BITS-1:0] rem_reg, rem_next;
    logic [MAX_FRAC_W-1:0]   fc_reg, fc_next;
    logic                    err_reg, err_next;
    logic                    last_item_reg, last_item_next;
    logic                    frac_reg, frac_next;

    logic                    m_valid_reg;
    logic [3:0]              m_quotient_reg;
    logic                    m_is_fraction_reg;
    logic                    m_last_reg;
    logic [31:0]             m_remainder_reg;
    logic                    m_error_reg;

    dld_div_ctrl_t           div_ctrl;
    dld_div_stat_t           div_stat;
    logic [RW-1:0]           div_dividend;
    logic [DIVISOR_BITS-1:0] div_rem;

    logic                    accept;
    logic                    div_zero;
    logic [3:0]              digit_clamped;
    logic [RW-1:0]           r_accept;
    logic [RW-1:0]           r_cont;
    logic                    emit;
    logic                    cont;
    logic                    clear;
    logic [MAX_FRAC_W-1:0]   limit;
    logic [MAX_FRAC_W-1:0]   fc_inc;
    logic                    frac_done;
    logic [3:0]              e_quotient;
    logic                    e_frac;
    logic                    e_last;
    logic [DIVISOR_BITS-1:0] e_remainder;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign div_zero  = (divisor_reg == '0);

    assign digit_clamped = (s_digit > DIGIT_MAX) ? DIGIT_MAX : s_digit;
    assign r_accept = RW'({rem_reg, 3'b000}) + RW'({rem_reg, 1'b0}) + RW'(digit_clamped);
    assign r_cont   = RW'({div_rem, 3'b000}) + RW'({div_rem, 1'b0});

    assign limit     = (max_frac_reg > LIMIT_CAP) ? LIMIT_CAP : max_frac_reg;
    assign fc_inc    = fc_reg + MAX_FRAC_W'(1);
    assign frac_done = (div_rem == '0) || (fc_inc >= limit);

    assign emit = (state_reg == ST_WAIT) && (err_reg || div_stat.done)
                  && (!m_valid_reg || m_ready);

    always_comb begin
        e_quotient  = div_stat.quotient;
        e_frac      = 1'b0;
        e_last      = 1'b0;
        e_remainder = '0;
        clear       = 1'b0;
        cont        = 1'b0;
        fc_next     = fc_reg;
        if (err_reg) begin
            e_quotient = '0;
            e_last     = last_item_reg;
            clear      = last_item_reg;
        end else if (!last_item_reg) begin
            e_last = 1'b0;
        end else if (!frac_reg) begin
            fc_next = '0;
            if (div_rem == '0 || limit == '0) begin
                e_last      = 1'b1;
                e_remainder = div_rem;
                clear       = 1'b1;
            end else begin
                cont = 1'b1;
            end
        end else begin
            e_frac = 1'b1;
            if (frac_done) begin
                e_last      = 1'b1;
                e_remainder = div_rem;
                clear       = 1'b1;
            end else begin
                cont    = 1'b1;
                fc_next = fc_inc;
            end
        end
        if (clear) begin
            fc_next = '0;
        end
    end

    always_comb begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        err_next       = err_reg;
        last_item_next = last_item_reg;
        frac_next      = frac_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next     = ST_WAIT;
                    err_next       = div_zero;
                    last_item_next = s_last_digit;
                    frac_next      = 1'b0;
                end
            end
            ST_WAIT: begin
                if (emit) begin
                    if (clear) begin
                        rem_next = '0;
                    end else if (!err_reg) begin
                        rem_next = div_rem;
                    end
                    if (cont) begin
                        frac_next = 1'b1;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign div_ctrl.start = (accept && !div_zero) || (emit && cont);
    assign div_ctrl.wide  = accept && !(rem_reg < divisor_reg);
    assign div_dividend   = accept ? r_accept : r_cont;

    dld_div_unit #(
        .DIVISOR_BITS(DIVISOR_BITS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (div_ctrl),
        .dividend  (div_dividend),
        .divisor   (divisor_reg),
        .stat      (div_stat),
        .remainder (div_rem)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            divisor_reg   <= DIVISOR_BITS'(1);
            max_frac_reg  <= MAX_FRAC_RESET;
            rem_reg       <= '0;
            fc_reg        <= '0;
            err_reg       <= 1'b0;
            last_item_reg <= 1'b0;
            frac_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rem_reg       <= rem_next;
            err_reg       <= err_next;
            last_item_reg <= last_item_next;
            frac_reg      <= frac_next;
            if (emit) begin
                fc_reg <= fc_next;
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_DIVISOR) begin
                    divisor_reg <= cfg_data[DIVISOR_BITS-1:0];
                end else if (cfg_index == CFG_MAX_FRAC) begin
                    max_frac_reg <= cfg_data[MAX_FRAC_W-1:0];
                end
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (emit) begin
            m_quotient_reg    <= e_quotient;
            m_is_fraction_reg <= e_frac;
            m_last_reg        <= e_last;
            m_remainder_reg   <= 32'(e_remainder);
            m_error_reg       <= err_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_quotient_digit  = m_quotient_reg;
    assign m_is_fraction     = m_is_fraction_reg;
    assign m_last            = m_last_reg;
    assign m_final_remainder = m_remainder_reg;
    assign m_divide_error    = m_error_reg;

    // A quotient digit is always a decimal digit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_quotient_digit <= DIGIT_MAX)
        else $error("quotient digit above nine");

    // Error beats never carry a fraction digit or a remainder.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_divide_error |-> !m_is_fraction && m_final_remainder == '0)
        else $error("error beat carries data");

    // Only the final beat of a division carries a remainder.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> m_final_remainder == '0)
        else $error("remainder on a beat that is not final");

    // The divider never runs while the block takes a new digit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !div_stat.busy)
        else $error("divider busy while idle");

endmodule
